>>> hw/rtl/tpw_pkg.sv
`timescale 1ns / 1ps

package tpw_pkg;

   // command codes of an input transaction, code three is ignored
   localparam logic [1:0] CMD_CAL     = 2'd0;
   localparam logic [1:0] CMD_DRIVE   = 2'd1;
   localparam logic [1:0] CMD_NEUTRAL = 2'd2;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned TILT_W   = 13;
   localparam int unsigned PULSE_W  = 12;
   localparam int unsigned SGAIN_W  = 5;
   localparam int unsigned DGAIN_W  = 6;
   // raw pulse before clamping, wide enough for gain times tilt plus centre
   localparam int unsigned RAW_W    = 19;

   localparam logic [PULSE_W-1:0] PULSE_CENTER = 12'd2767;
   localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd2029;
   localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'd3505;

   localparam logic signed [RAW_W-1:0] CENTER_RAW = RAW_W'(PULSE_CENTER);
   localparam logic signed [RAW_W-1:0] MIN_RAW    = RAW_W'(PULSE_MIN);
   localparam logic signed [RAW_W-1:0] MAX_RAW    = RAW_W'(PULSE_MAX);

   // reciprocal constants, exact for magnitudes below 2**13
   localparam int unsigned RECIP_W     = 15;
   localparam int unsigned DIV10_SHIFT = 18;
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 15'd26215;
   localparam int unsigned DIV5_SHIFT  = 17;
   localparam logic [RECIP_W-1:0] DIV5_RECIP  = 15'd26215;

   typedef struct packed {
      logic add;
      logic clr;
   } acc_ctl_type;

   function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [RAW_W-1:0] v);
      logic [PULSE_W-1:0] r;
      if (v > MAX_RAW) begin
         r = PULSE_MAX;
      end else if (v < MIN_RAW) begin
         r = PULSE_MIN;
      end else begin
         r = v[PULSE_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/tpw_accum.sv
`timescale 1ns / 1ps

module tpw_accum #(
   parameter int unsigned N = 32,
   localparam int unsigned SUM_W = tpw_pkg::SAMPLE_W + $clog2(N),
   localparam int unsigned CNT_W = $clog2(N)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpw_pkg::acc_ctl_type                ctl,
   input  logic signed [tpw_pkg::SAMPLE_W-1:0] sample_x,
   input  logic signed [tpw_pkg::SAMPLE_W-1:0] sample_y,
   output logic signed [SUM_W-1:0]             total_x,
   output logic signed [SUM_W-1:0]             total_y,
   output logic                                last
);

   logic signed [SUM_W-1:0] sum_x_ff;
   logic signed [SUM_W-1:0] sum_y_ff;
   logic [CNT_W-1:0]        cnt_ff;

   // window total including the sample being added
   assign total_x = sum_x_ff + SUM_W'(sample_x);
   assign total_y = sum_y_ff + SUM_W'(sample_y);
   assign last    = (cnt_ff == CNT_W'(N - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
      end else if (ctl.clr) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         cnt_ff   <= '0;
      end else if (ctl.add) begin
         if (last) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            cnt_ff   <= '0;
         end else begin
            sum_x_ff <= total_x;
            sum_y_ff <= total_y;
            cnt_ff   <= cnt_ff + CNT_W'(1);
         end
      end
   end

endmodule

>>> hw/rtl/tpw_avg_div.sv
`timescale 1ns / 1ps

module tpw_avg_div #(
   parameter int unsigned N    = 32,
   parameter int unsigned IN_W = 17
) (
   input  logic signed [IN_W-1:0]              sum,
   output logic signed [tpw_pkg::SAMPLE_W-1:0] quot
);

   // floor(mag / N) as mag * ceil-ish reciprocal, exact for mag below 2**IN_W
   localparam int unsigned SHIFT   = IN_W + $clog2(N) + 1;
   localparam longint unsigned RECIP = (64'd1 << SHIFT) / N + 64'd1;
   localparam int unsigned RECIP_W = SHIFT - $clog2(N) + 2;
   localparam int unsigned PROD_W  = IN_W + RECIP_W;
   localparam int unsigned Q_W     = tpw_pkg::SAMPLE_W + 1;

   logic [IN_W-1:0]   mag;
   logic [PROD_W-1:0] prod;
   logic [Q_W-1:0]    qmag;
   logic [Q_W-1:0]    qsgn;

   always_comb begin
      mag  = sum[IN_W-1] ? IN_W'(-sum) : IN_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      qmag = Q_W'(prod >> SHIFT);
      // truncation toward zero: divide the magnitude, then restore the sign
      qsgn = sum[IN_W-1] ? -qmag : qmag;
      quot = $signed(qsgn[tpw_pkg::SAMPLE_W-1:0]);
   end

endmodule

>>> hw/rtl/tilt_to_pulse_width_controller_unit.sv
`timescale 1ns / 1ps

// channel   direction  ports
// req       in         req_valid/req_ready, cmd, x_high, y_high, drive_gain
// rsp       out        rsp_valid/rsp_ready, drive_pulse, steer_pulse, tilt_x, tilt_y
// csr       in         csr_write_en, csr_write_data (steer gain)
//
// one transaction accepted per cycle while req_ready is high; a result passes after the
// transaction that caused it through input, sum, quotient, product and output registers
// accumulation is one add per cycle as the input register advances, so it never limits the rate
// each stage holds while the one after it is full; bubbles close up, req_ready stays high
// while any stage is free
// synchronous reset clears valids, sums, counts, offsets and the gain

module tilt_to_pulse_width_controller_unit #(
   parameter int unsigned RUN_SAMPLES = 32,
   parameter int unsigned CAL_SAMPLES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [tpw_pkg::SGAIN_W-1:0]           csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [tpw_pkg::CMD_W-1:0]             req_cmd,
   input  logic [tpw_pkg::BYTE_W-1:0]            req_x_high,
   input  logic [tpw_pkg::BYTE_W-1:0]            req_y_high,
   input  logic [tpw_pkg::DGAIN_W-1:0]           req_drive_gain,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tpw_pkg::PULSE_W-1:0]           rsp_drive_pulse,
   output logic [tpw_pkg::PULSE_W-1:0]           rsp_steer_pulse,
   output logic signed [tpw_pkg::TILT_W-1:0]     rsp_tilt_x,
   output logic signed [tpw_pkg::TILT_W-1:0]     rsp_tilt_y
);

   localparam int unsigned CAL_SUM_W = tpw_pkg::SAMPLE_W + $clog2(CAL_SAMPLES);
   localparam int unsigned RUN_SUM_W = tpw_pkg::SAMPLE_W + $clog2(RUN_SAMPLES);
   localparam int unsigned SUM_W     = (CAL_SUM_W > RUN_SUM_W) ? CAL_SUM_W : RUN_SUM_W;
   localparam int unsigned SW        = tpw_pkg::SAMPLE_W;
   localparam int unsigned TW        = tpw_pkg::TILT_W;
   localparam int unsigned RW        = tpw_pkg::RAW_W;
   localparam int unsigned DW        = tpw_pkg::DGAIN_W;
   localparam int unsigned AX_W      = 9;
   localparam int unsigned QY_W      = 11;
   localparam int unsigned DIFF_W    = 12;
   localparam int unsigned P_W       = TW + tpw_pkg::RECIP_W;

   // configuration
   logic [tpw_pkg::SGAIN_W-1:0] steer_gain_ff;

   // stage ready chain
   logic out_ready;
   logic s3_ready;
   logic s2_ready;
   logic s1_ready;
   logic s0_adv;
   logic s1_adv;

   // input register
   logic                          s0_valid_ff;
   logic [tpw_pkg::CMD_W-1:0]     s0_cmd_ff;
   logic [tpw_pkg::BYTE_W-1:0]    s0_x_ff;
   logic [tpw_pkg::BYTE_W-1:0]    s0_y_ff;
   logic [DW-1:0]                 s0_dg_ff;
   logic signed [SW-1:0]          s0_sx;
   logic signed [SW-1:0]          s0_sy;

   // window accumulators
   tpw_pkg::acc_ctl_type          cal_ctl;
   tpw_pkg::acc_ctl_type          run_ctl;
   logic signed [CAL_SUM_W-1:0]   cal_total_x;
   logic signed [CAL_SUM_W-1:0]   cal_total_y;
   logic                          cal_last;
   logic signed [RUN_SUM_W-1:0]   run_total_x;
   logic signed [RUN_SUM_W-1:0]   run_total_y;
   logic                          run_last;

   // sum stage
   logic                          s1_valid_in;
   logic signed [SUM_W-1:0]       s1_sum_x_in;
   logic signed [SUM_W-1:0]       s1_sum_y_in;
   logic                          s1_valid_ff;
   logic [tpw_pkg::CMD_W-1:0]     s1_cmd_ff;
   logic signed [SUM_W-1:0]       s1_sum_x_ff;
   logic signed [SUM_W-1:0]       s1_sum_y_ff;
   logic [DW-1:0]                 s1_dg_ff;
   logic signed [SW-1:0]          cal_q_x;
   logic signed [SW-1:0]          cal_q_y;
   logic signed [SW-1:0]          run_q_x;
   logic signed [SW-1:0]          run_q_y;

   // calibration offsets
   logic signed [SW-1:0]          offset_x_ff;
   logic signed [SW-1:0]          offset_y_ff;

   // quotient stage
   logic                          s2_valid_ff;
   logic                          s2_neutral_ff;
   logic signed [SW-1:0]          s2_qx_ff;
   logic signed [SW-1:0]          s2_qy_ff;
   logic [DW-1:0]                 s2_dg_ff;

   // product stage
   logic signed [TW-1:0]          tx_in;
   logic signed [TW-1:0]          ty_in;
   logic [TW-1:0]                 tx_mag;
   logic [TW-1:0]                 ty_mag;
   logic [P_W-1:0]                p10;
   logic [P_W-1:0]                p5;
   logic [QY_W-1:0]               qy_mag;
   logic signed [RW-1:0]          sprod_in;
   logic [AX_W-1:0]               ax_in;
   logic signed [QY_W-1:0]        qy_in;
   logic                          s3_valid_ff;
   logic                          s3_neutral_ff;
   logic signed [TW-1:0]          s3_tx_ff;
   logic signed [TW-1:0]          s3_ty_ff;
   logic signed [RW-1:0]          s3_sprod_ff;
   logic [AX_W-1:0]               s3_ax_ff;
   logic signed [QY_W-1:0]        s3_qy_ff;
   logic [DW-1:0]                 s3_dg_ff;

   // output stage
   logic signed [DIFF_W-1:0]      diff;
   logic signed [RW-1:0]          dprod;
   logic signed [RW-1:0]          drive_raw;
   logic signed [RW-1:0]          steer_raw;
   logic                          rsp_valid_ff;
   logic [tpw_pkg::PULSE_W-1:0]   rsp_drive_ff;
   logic [tpw_pkg::PULSE_W-1:0]   rsp_steer_ff;
   logic signed [TW-1:0]          rsp_tx_ff;
   logic signed [TW-1:0]          rsp_ty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_gain_ff <= '0;
      end else if (csr_write_en) begin
         steer_gain_ff <= csr_write_data;
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = !s0_valid_ff || s1_ready;
   assign s0_adv    = s0_valid_ff && s1_ready;
   assign s1_adv    = s1_valid_ff && s2_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s0_cmd_ff <= req_cmd;
         s0_x_ff   <= req_x_high;
         s0_y_ff   <= req_y_high;
         s0_dg_ff  <= req_drive_gain;
      end
   end

   // byte times sixteen is the byte with four zero bits below it
   assign s0_sx = $signed({s0_x_ff, 4'b0000});
   assign s0_sy = $signed({s0_y_ff, 4'b0000});

   always_comb begin
      cal_ctl     = '0;
      run_ctl     = '0;
      s1_valid_in = 1'b0;
      s1_sum_x_in = SUM_W'(run_total_x);
      s1_sum_y_in = SUM_W'(run_total_y);
      case (s0_cmd_ff)
         tpw_pkg::CMD_CAL: begin
            cal_ctl.add = s0_adv;
            s1_valid_in = s0_valid_ff && cal_last;
            s1_sum_x_in = SUM_W'(cal_total_x);
            s1_sum_y_in = SUM_W'(cal_total_y);
         end
         tpw_pkg::CMD_DRIVE: begin
            run_ctl.add = s0_adv;
            s1_valid_in = s0_valid_ff && run_last;
         end
         tpw_pkg::CMD_NEUTRAL: begin
            run_ctl.clr = s0_adv;
            s1_valid_in = s0_valid_ff;
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
   end

   tpw_accum #(.N(CAL_SAMPLES)) u_cal_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cal_ctl),
      .sample_x (s0_sx),
      .sample_y (s0_sy),
      .total_x  (cal_total_x),
      .total_y  (cal_total_y),
      .last     (cal_last)
   );

   tpw_accum #(.N(RUN_SAMPLES)) u_run_accum (
      .clock    (clock),
      .reset    (reset),
      .ctl      (run_ctl),
      .sample_x (s0_sx),
      .sample_y (s0_sy),
      .total_x  (run_total_x),
      .total_y  (run_total_y),
      .last     (run_last)
   );

   // sum stage: only window ends and neutral requests get this far
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cmd_ff   <= s0_cmd_ff;
         s1_sum_x_ff <= s1_sum_x_in;
         s1_sum_y_ff <= s1_sum_y_in;
         s1_dg_ff    <= s0_dg_ff;
      end
   end

   tpw_avg_div #(.N(CAL_SAMPLES), .IN_W(SUM_W)) u_cal_div_x (
      .sum  (s1_sum_x_ff),
      .quot (cal_q_x)
   );

   tpw_avg_div #(.N(CAL_SAMPLES), .IN_W(SUM_W)) u_cal_div_y (
      .sum  (s1_sum_y_ff),
      .quot (cal_q_y)
   );

   tpw_avg_div #(.N(RUN_SAMPLES), .IN_W(SUM_W)) u_run_div_x (
      .sum  (s1_sum_x_ff),
      .quot (run_q_x)
   );

   tpw_avg_div #(.N(RUN_SAMPLES), .IN_W(SUM_W)) u_run_div_y (
      .sum  (s1_sum_y_ff),
      .quot (run_q_y)
   );

   // offsets change as the calibration transaction leaves, so any younger
   // drive window reads them only once it is behind
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (s1_adv && (s1_cmd_ff == tpw_pkg::CMD_CAL)) begin
         offset_x_ff <= cal_q_x;
         offset_y_ff <= cal_q_y;
      end
   end

   // quotient stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff && (s1_cmd_ff != tpw_pkg::CMD_CAL);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_neutral_ff <= (s1_cmd_ff == tpw_pkg::CMD_NEUTRAL);
         s2_qx_ff      <= run_q_x;
         s2_qy_ff      <= run_q_y;
         s2_dg_ff      <= s1_dg_ff;
      end
   end

   // tilt, steering product and the two constant divisions
   always_comb begin
      tx_in    = TW'(s2_qx_ff) - TW'(offset_x_ff);
      ty_in    = TW'(s2_qy_ff) - TW'(offset_y_ff);
      tx_mag   = tx_in[TW-1] ? TW'(-tx_in) : TW'(tx_in);
      ty_mag   = ty_in[TW-1] ? TW'(-ty_in) : TW'(ty_in);
      sprod_in = RW'($signed({1'b0, steer_gain_ff})) * RW'(tx_in);
      p10      = P_W'(tx_mag) * P_W'(tpw_pkg::DIV10_RECIP);
      p5       = P_W'(ty_mag) * P_W'(tpw_pkg::DIV5_RECIP);
      ax_in    = AX_W'(p10 >> tpw_pkg::DIV10_SHIFT);
      qy_mag   = QY_W'(p5 >> tpw_pkg::DIV5_SHIFT);
      qy_in    = ty_in[TW-1] ? $signed(-qy_mag) : $signed(qy_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_neutral_ff <= s2_neutral_ff;
         s3_tx_ff      <= tx_in;
         s3_ty_ff      <= ty_in;
         s3_sprod_ff   <= sprod_in;
         s3_ax_ff      <= ax_in;
         s3_qy_ff      <= qy_in;
         s3_dg_ff      <= s2_dg_ff;
      end
   end

   // dg*(y/5) - dg*|x/10| folded into one product
   always_comb begin
      diff      = DIFF_W'(s3_qy_ff) - $signed(DIFF_W'(s3_ax_ff));
      dprod     = RW'($signed({1'b0, s3_dg_ff})) * RW'(diff);
      drive_raw = tpw_pkg::CENTER_RAW + dprod;
      steer_raw = tpw_pkg::CENTER_RAW - s3_sprod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         if (s3_neutral_ff) begin
            rsp_drive_ff <= tpw_pkg::PULSE_CENTER;
            rsp_steer_ff <= tpw_pkg::PULSE_CENTER;
            rsp_tx_ff    <= '0;
            rsp_ty_ff    <= '0;
         end else begin
            rsp_drive_ff <= tpw_pkg::clamp_pulse(drive_raw);
            rsp_steer_ff <= tpw_pkg::clamp_pulse(steer_raw);
            rsp_tx_ff    <= s3_tx_ff;
            rsp_ty_ff    <= s3_ty_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_pulse = rsp_drive_ff;
   assign rsp_steer_pulse = rsp_steer_ff;
   assign rsp_tilt_x      = rsp_tx_ff;
   assign rsp_tilt_y      = rsp_ty_ff;

endmodule
